// ===== rtl/core/stpq_pkg.sv =====
// Package for the stable min-priority queue core.
// Holds the operation and status codes, the cell entry and command types.
// Used by every module of the core and by the port checker.
package stpq_pkg;

	localparam int ITEM_W   = 16;
	localparam int PRIO_W   = 32;
	localparam int KIND_W   = 3;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT   = 3'd0,
		KIND_CHANGE   = 3'd1,
		KIND_CONTAINS = 3'd2,
		KIND_POP      = 3'd3,
		KIND_PEEK     = 3'd4,
		KIND_CLEAR    = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_UNDERFLOW = 2'd2,
		STATUS_NOTFOUND  = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_REINS
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		logic              valid;
		logic [ITEM_W-1:0] item;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t          op;
		logic              front;
		logic [ITEM_W-1:0] item;
		logic [PRIO_W-1:0] prio;
	} cell_cmd_t;

endpackage

// ===== rtl/core/stpq_cell.sv =====
// One cell of the sorted queue chain: a single entry with its valid bit.
// Shifts toward the back on insert and toward the front on removal.
// Depends on stpq_pkg.
module stpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stpq_pkg::cell_cmd_t cmd,
	input  stpq_pkg::entry_t    left_ent,
	input  logic               left_ahead,
	input  stpq_pkg::entry_t    right_ent,
	input  logic               seen_in,
	output stpq_pkg::entry_t    ent,
	output logic               ahead,
	output logic               seen_out
);
	import stpq_pkg::*;

	logic              valid_q;
	logic [ITEM_W-1:0] item_q;
	logic [PRIO_W-1:0] prio_q;
	entry_t            next_ent;
	logic              hit;

	assign ent      = '{valid: valid_q, item: item_q, prio: prio_q};
	assign ahead    = valid_q && (prio_q <= cmd.prio);
	assign hit      = valid_q && (cmd.front || (item_q == cmd.item));
	assign seen_out = seen_in || hit;

	always_comb begin
		next_ent = ent;
		unique case (cmd.op)
			CELL_HOLD: begin
				next_ent = ent;
			end
			CELL_INSERT: begin
				if (ahead) begin
					next_ent = ent;
				end else if (left_ahead) begin
					next_ent = '{valid: 1'b1, item: cmd.item, prio: cmd.prio};
				end else begin
					next_ent = left_ent;
				end
			end
			CELL_REMOVE: begin
				if (seen_out) begin
					next_ent = right_ent;
				end
			end
			CELL_CLEAR: begin
				next_ent.valid = 1'b0;
			end
			default: begin
				next_ent = ent;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= next_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= next_ent.item;
		prio_q <= next_ent.prio;
	end

endmodule

// ===== rtl/core/stable_min_priority_queue_core.sv =====
// Top level of the stable min-priority queue: a chain of sorted entry cells
// with the operation sequencer and the result register. Depends on stpq_pkg
// and stpq_cell.
//
// Channel  Dir  Group          Contents
// s_axis   in   tdata/tuser    tuser: kind; tdata: item, priority_req
// m_axis   out  tdata          item_out, found, count, is_empty, status
//
// Every operation makes one pass through the cell chain; a change priority that
// finds its item makes a removal pass, then an insertion pass through the same chain.
// The result is registered and shows in the cycle after the item is accepted;
// for a successful change priority it is loaded in the reinsertion state.
// A result that waits for m_axis_tready holds s_axis_tready low until taken.
// Reset empties the queue at once; no clearing pass is needed.
module stable_min_priority_queue_core #(
	parameter int CAPACITY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Bits from low: item [15:0], priority_req [47:16].
	input  logic [stpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Bits from low: kind [2:0].
	input  logic [stpq_pkg::KIND_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Bits from low: item_out [15:0], found [16], count [23:17],
	// is_empty [24], status [26:25], zero [31:27].
	output logic [stpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import stpq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [ITEM_W-1:0] item_q;
	logic [PRIO_W-1:0] prio_q;
	logic              out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              acc;
	kind_t             kind;
	logic [ITEM_W-1:0] in_item;
	logic [PRIO_W-1:0] in_prio;
	logic              full;
	logic              empty;
	logic              found_any;
	cell_cmd_t         cmd;
	logic              load;
	logic [ITEM_W-1:0] res_item;
	logic              res_found;
	status_t           res_status;

	entry_t ent_w    [0:CAPACITY+1];
	logic   ahead_w  [0:CAPACITY];
	logic   seen_w   [0:CAPACITY];

	assign kind    = kind_t'(s_axis_tuser);
	assign in_item = s_axis_tdata[ITEM_W-1:0];
	assign in_prio = s_axis_tdata[ITEM_W +: PRIO_W];
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);

	assign ent_w[0]          = '0;
	assign ent_w[CAPACITY+1] = '0;
	assign ahead_w[0]        = 1'b1;
	assign seen_w[0]         = 1'b0;
	assign found_any         = seen_w[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		stpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_ent    (ent_w[i]),
			.left_ahead  (ahead_w[i]),
			.right_ent   (ent_w[i+2]),
			.seen_in     (seen_w[i]),
			.ent         (ent_w[i+1]),
			.ahead       (ahead_w[i+1]),
			.seen_out    (seen_w[i+1])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (kind == KIND_CHANGE) && found_any) begin
					state_d = ST_REINS;
				end
			end
			ST_REINS: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '{op: CELL_HOLD, front: 1'b0, item: in_item, prio: in_prio};
		cnt_d         = cnt_q;
		load          = 1'b0;
		res_item      = '0;
		res_found     = 1'b0;
		res_status    = STATUS_OK;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = !out_vld_q || m_axis_tready;
				cmd.front     = (kind == KIND_POP);
				if (acc) begin
					load = 1'b1;
					unique case (kind)
						KIND_INSERT: begin
							if (full) begin
								res_status = STATUS_FULL;
							end else begin
								cmd.op = CELL_INSERT;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						KIND_CHANGE: begin
							if (found_any) begin
								cmd.op = CELL_REMOVE;
								cnt_d  = cnt_q - 1'b1;
								load   = 1'b0;
							end else begin
								res_status = STATUS_NOTFOUND;
							end
						end
						KIND_CONTAINS: begin
							res_found = found_any;
						end
						KIND_POP: begin
							if (empty) begin
								res_status = STATUS_UNDERFLOW;
							end else begin
								res_item = ent_w[1].item;
								cmd.op   = CELL_REMOVE;
								cnt_d    = cnt_q - 1'b1;
							end
						end
						KIND_PEEK: begin
							if (empty) begin
								res_status = STATUS_UNDERFLOW;
							end else begin
								res_item = ent_w[1].item;
							end
						end
						KIND_CLEAR: begin
							cmd.op = CELL_CLEAR;
							cnt_d  = '0;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_REINS: begin
				cmd       = '{op: CELL_INSERT, front: 1'b0, item: item_q, prio: prio_q};
				cnt_d     = cnt_q + 1'b1;
				load      = 1'b1;
				res_found = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_q <= in_item;
			prio_q <= in_prio;
		end
		if (load) begin
			out_data_q <= {5'b0, res_status, (cnt_d == '0), COUNT_W'(cnt_d),
				res_found, res_item};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/stpq_checker.sv =====
// Port checker for the stable min-priority queue core, bound to its top level.
// Watches only the stream ports. Depends on stpq_pkg.
module stpq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [stpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [stpq_pkg::KIND_W-1:0]      s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [stpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import stpq_pkg::*;

	logic    acc;
	status_t st;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign st  = status_t'(m_axis_tdata[26:25]);

	// Any item other than change priority gives its result in the next cycle.
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_axis_tuser != KIND_CHANGE) |=> m_axis_tvalid)
		else $error("result missing one cycle after accept");

	// A clear leaves an empty queue.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_axis_tuser == KIND_CLEAR) |=>
			(m_axis_tdata[23:17] == 7'd0) && m_axis_tdata[24])
		else $error("clear did not empty the queue");

	// A failed operation carries no item and no found flag.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st != STATUS_OK) |->
			(m_axis_tdata[15:0] == 16'd0) && !m_axis_tdata[16])
		else $error("failed result carries data");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind stable_min_priority_queue_core stpq_checker u_stpq_checker (.*);

// ===== test/tb_stable_min_priority_queue_core.sv =====
// Testbench for stable_min_priority_queue_core: a directed run and a random run, with a
// scoreboard class that keeps its own sorted queue and checks every result.
// Depends on stpq_pkg and the RTL of the core.
module tb_stable_min_priority_queue_core;
	import stpq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

	typedef struct {
		logic [ITEM_W-1:0]  item_out;
		logic               found;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		status_t            status;
	} queue_result_t;

	class sorted_queue_checker;
		logic [ITEM_W-1:0] held_item[QUEUE_DEPTH];
		logic [PRIO_W-1:0] held_prio[QUEUE_DEPTH];
		int fill;
		int errors;
		queue_result_t expected_results[$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function int locate(logic [ITEM_W-1:0] it);
			for (int k = 0; k < fill; k++) begin
				if (held_item[k] == it) begin
					return k;
				end
			end
			return -1;
		endfunction

		function void put_sorted(logic [ITEM_W-1:0] it, logic [PRIO_W-1:0] pr);
			int pos;
			pos = 0;
			while (pos < fill && held_prio[pos] <= pr) begin
				pos++;
			end
			for (int k = fill; k > pos; k--) begin
				held_item[k] = held_item[k-1];
				held_prio[k] = held_prio[k-1];
			end
			held_item[pos] = it;
			held_prio[pos] = pr;
			fill++;
		endfunction

		function void remove_at(int pos);
			for (int k = pos; k + 1 < fill; k++) begin
				held_item[k] = held_item[k+1];
				held_prio[k] = held_prio[k+1];
			end
			fill--;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [ITEM_W-1:0] it,
				logic [PRIO_W-1:0] pr);
			queue_result_t r;
			int where;
			r.item_out = '0;
			r.found = 1'b0;
			r.status = STATUS_OK;
			case (kind)
				KIND_INSERT: begin
					if (fill >= QUEUE_DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						put_sorted(it, pr);
					end
				end
				KIND_CHANGE: begin
					where = locate(it);
					if (where >= 0) begin
						remove_at(where);
						put_sorted(it, pr);
						r.found = 1'b1;
					end else begin
						r.status = STATUS_NOTFOUND;
					end
				end
				KIND_CONTAINS: begin
					r.found = (locate(it) >= 0);
				end
				KIND_POP: begin
					if (fill == 0) begin
						r.status = STATUS_UNDERFLOW;
					end else begin
						r.item_out = held_item[0];
						remove_at(0);
					end
				end
				KIND_PEEK: begin
					if (fill == 0) begin
						r.status = STATUS_UNDERFLOW;
					end else begin
						r.item_out = held_item[0];
					end
				end
				KIND_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			r.count = fill[COUNT_W-1:0];
			r.is_empty = (fill == 0);
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			queue_result_t exp;
			queue_result_t got;
			got.item_out = d[15:0];
			got.found = d[16];
			got.count = d[23:17];
			got.is_empty = d[24];
			got.status = status_t'(d[26:25]);
			if (expected_results.size() == 0) begin
				$display("%0t: result %h with none expected", $time, d);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.item_out !== exp.item_out) begin
				$display("%0t: item_out expected %h got %h", $time, exp.item_out, got.item_out);
				errors++;
			end
			if (got.found !== exp.found) begin
				$display("%0t: found expected %b got %b", $time, exp.found, got.found);
				errors++;
			end
			if (got.count !== exp.count) begin
				$display("%0t: count expected %0d got %0d", $time, exp.count, got.count);
				errors++;
			end
			if (got.is_empty !== exp.is_empty) begin
				$display("%0t: is_empty expected %b got %b", $time, exp.is_empty, got.is_empty);
				errors++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]      s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic              steady = 1'b0;
	logic [ITEM_W-1:0] item_pool[16];
	sorted_queue_checker sb = new();

	stable_min_priority_queue_core #(
		.CAPACITY(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
		end
	end

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ITEM_W-1:0] it,
			input logic [PRIO_W-1:0] pr);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 4);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {pr, it};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_results.size() != 0);
	endtask

	function automatic logic [ITEM_W-1:0] pick_item();
		if ($urandom_range(0, 99) < 80) begin
			return item_pool[$urandom_range(0, 15)];
		end
		return ITEM_W'($urandom);
	endfunction

	function automatic logic [PRIO_W-1:0] pick_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return PRIO_W'($urandom_range(0, 7));
		end else if (r < 80) begin
			return PRIO_W'($urandom);
		end else if (r < 90) begin
			return '0;
		end
		return '1;
	endfunction

	// Modes: 0 fills the queue toward full, 1 mixes all operations, 2 drains.
	function automatic logic [KIND_W-1:0] pick_kind(int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 85) return KIND_INSERT;
				if (r < 90) return KIND_CHANGE;
				if (r < 94) return KIND_CONTAINS;
				if (r < 97) return KIND_POP;
				if (r < 99) return KIND_PEEK;
			end
			1: begin
				if (r < 30) return KIND_INSERT;
				if (r < 50) return KIND_CHANGE;
				if (r < 65) return KIND_CONTAINS;
				if (r < 85) return KIND_POP;
				if (r < 93) return KIND_PEEK;
				if (r < 96) return KIND_CLEAR;
			end
			default: begin
				if (r < 10) return KIND_INSERT;
				if (r < 20) return KIND_CHANGE;
				if (r < 30) return KIND_CONTAINS;
				if (r < 89) return KIND_POP;
				if (r < 99) return KIND_PEEK;
			end
		endcase
		return $urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B;
	endfunction

	initial begin
		foreach (item_pool[i]) item_pool[i] = ITEM_W'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_POP, 16'h0000, '0);
		send_request(KIND_PEEK, 16'h0000, '0);
		send_request(KIND_CHANGE, 16'h1234, 32'd9);
		send_request(KIND_CONTAINS, 16'h1234, '0);
		send_request(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
		send_request(KIND_INSERT, 16'h1234, 32'd5);
		send_request(KIND_INSERT, 16'h5678, 32'd5);
		send_request(KIND_INSERT, 16'h1234, 32'd5);
		send_request(KIND_CONTAINS, 16'h1234, '0);
		send_request(KIND_CONTAINS, 16'hABCD, '0);
		send_request(KIND_CHANGE, 16'h1234, 32'd0);
		send_request(KIND_CHANGE, 16'h9999, 32'd1);
		send_request(KIND_PEEK, 16'h0000, '0);
		send_request(KIND_POP, 16'h0000, '0);
		send_request(KIND_POP, 16'h0000, '0);
		send_request(KIND_UNUSED_A, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(KIND_UNUSED_B, 16'h0000, '0);
		send_request(KIND_POP, 16'h0000, '0);
		send_request(KIND_CLEAR, 16'h0000, '0);
		send_request(KIND_POP, 16'h0000, '0);
		send_request(KIND_INSERT, 16'h8000, 32'h8000_0000);
		send_request(KIND_INSERT, 16'h7FFF, 32'h7FFF_FFFF);
		send_request(KIND_CHANGE, 16'h7FFF, 32'hFFFF_FFFF);
		send_request(KIND_POP, 16'h0000, '0);
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 220 && i < 300);
			if (i == 260) begin
				hold_until_drained();
			end
			send_request(pick_kind((i / 100) % 3), pick_item(), pick_priority());
		end
		steady = 1'b0;
		hold_until_drained();
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
